// ===== design/assert_macros.svh =====
// Assertion macros for the checker of the path search core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gap_pkg.sv =====
// Codes and fixed constants of the grid path search core.
package gap_pkg;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_FOUND  = 2'd1;
	localparam logic [1:0] STAT_NOPATH = 2'd2;
	localparam logic [1:0] STAT_RANGE  = 2'd3;

	localparam logic [1:0] MARK_NONE   = 2'd0;
	localparam logic [1:0] MARK_OPEN   = 2'd1;
	localparam logic [1:0] MARK_CLOSED = 2'd2;

	localparam logic [3:0] COST_STRAIGHT = 4'd10;
	localparam logic [3:0] COST_DIAG     = 4'd14;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

endpackage

// ===== design/gap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/grid_astar_path_search_core.sv =====
// A* path search core: map store, binary heap open list, path trace and readout.
//
// After reset the core sweeps the walk map to all-walkable, one cell a cycle, with
// s_axis_tready low. A search is sequenced over one set of single-write, single-read RAMs,
// so its time is set by RAM port turns: setup, a sweep of the open/closed marks, then per
// expanded cell a pop and a sift-down with a compare per level, a visit of each neighbor
// with a sift-up, and finally a trace of the path cells. One word is accepted at a time;
// a finished result sits in the output register while the next word is taken.
module grid_astar_path_search_core
	import gap_pkg::*;
#(
	parameter int GRID_W = 32,
	parameter int GRID_H = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// cell_x, cell_y, cell_blocked, start_x, start_y, target_x, target_y,
	// diagonal_off, heap_tie_mode, path_index, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// path_length, step_x, step_y, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [1:0]             m_axis_tuser
);

	localparam int CELLS = GRID_W * GRID_H;
	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int AW    = XW + YW;
	localparam int MAPD  = 1 << AW;
	localparam int HD    = CELLS + 2;
	localparam int HW    = $clog2(HD);
	localparam int GW    = $clog2(14 * CELLS + 1);
	localparam int FW    = $clog2(14 * CELLS + 10 * (GRID_W + GRID_H) + 1);
	localparam int LW    = $clog2(CELLS + 1);
	localparam int PW    = $clog2(CELLS);

	typedef enum logic [29:0] {
		S_INIT = 30'd1 << 0,  S_IDLE = 30'd1 << 1,  S_WR   = 30'd1 << 2,
		S_RD0  = 30'd1 << 3,  S_RD1  = 30'd1 << 4,  S_TGT  = 30'd1 << 5,
		S_TCHK = 30'd1 << 6,  S_CLR  = 30'd1 << 7,  S_SEED = 30'd1 << 8,
		S_POP0 = 30'd1 << 9,  S_POP1 = 30'd1 << 10, S_POP2 = 30'd1 << 11,
		S_POP3 = 30'd1 << 12, S_SD0  = 30'd1 << 13, S_SD1  = 30'd1 << 14,
		S_SD2  = 30'd1 << 15, S_SD3  = 30'd1 << 16, S_SD4  = 30'd1 << 17,
		S_NB0  = 30'd1 << 18, S_NB1  = 30'd1 << 19, S_NB2  = 30'd1 << 20,
		S_NB3  = 30'd1 << 21, S_SU0  = 30'd1 << 22, S_SU1  = 30'd1 << 23,
		S_SU2  = 30'd1 << 24, S_SU3  = 30'd1 << 25, S_NEXT = 30'd1 << 26,
		S_PT0  = 30'd1 << 27, S_PT1  = 30'd1 << 28, S_FIN  = 30'd1 << 29
	} state_t;

	state_t state_q;

	// input word fields
	logic [1:0] in_action;
	logic [4:0] in_cx, in_cy, in_sx, in_sy, in_tx, in_ty;
	logic       in_blk, in_ortho, in_mode;
	logic [9:0] in_idx;

	assign in_action = s_axis_tuser[1:0];
	assign in_cx     = s_axis_tdata[4:0];
	assign in_cy     = s_axis_tdata[9:5];
	assign in_blk    = s_axis_tdata[10];
	assign in_sx     = s_axis_tdata[15:11];
	assign in_sy     = s_axis_tdata[20:16];
	assign in_tx     = s_axis_tdata[25:21];
	assign in_ty     = s_axis_tdata[30:26];
	assign in_ortho  = s_axis_tdata[31];
	assign in_mode   = s_axis_tdata[32];
	assign in_idx    = s_axis_tdata[42:33];

	logic [AW-1:0] clr_q;
	logic [XW-1:0] sx_q, tx_q;
	logic [YW-1:0] sy_q, ty_q;
	logic          ortho_q, mode_q, wr_ok_q, blk_q;
	logic [AW-1:0] wcell_q;
	logic [9:0]    idx_q;
	logic [HW-1:0] n_q, u_q, v_q, m_q, kpos_q;
	logic [AW-1:0] pc_q, sink_q, cl_q, cr_q, cv_q, nc_q;
	logic [GW-1:0] g_pc_q, gnew_q, gold_q;
	logic [FW-1:0] fsink_q, fl_q, fnew_q, hsum_q;
	logic          has_r_q, diag_q, open_q, allow_eq_q, tgt_open_q;
	logic [1:0]    dxi_q, dyi_q;
	logic [LW-1:0] len_q, stored_len_q;
	logic [1:0]    res_status_q;
	logic [4:0]    res_x_q, res_y_q;
	logic          m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [1:0]    m_user_q;

	// RAM ports
	logic          walk_we, walk_wd, walk_rd;
	logic [AW-1:0] walk_wa, walk_ra;
	logic          mark_we;
	logic [1:0]    mark_wd, mark_rd;
	logic [AW-1:0] mark_wa, mark_ra;
	logic          g_we;
	logic [GW-1:0] g_wd, g_rd;
	logic [AW-1:0] g_wa, g_ra;
	logic          f_we;
	logic [FW-1:0] f_wd, f_rd;
	logic [AW-1:0] f_wa, f_ra;
	logic          par_we;
	logic [AW-1:0] par_wd, par_rd, par_wa, par_ra;
	logic          pos_we;
	logic [HW-1:0] pos_wd, pos_rd;
	logic [AW-1:0] pos_wa, pos_ra;
	logic          heap_we;
	logic [AW-1:0] heap_wd, heap_rd;
	logic [HW-1:0] heap_wa, heap_ra;
	logic          path_we;
	logic [AW-1:0] path_wd, path_rd;
	logic [PW-1:0] path_wa, path_ra;

	logic [AW-1:0] s_cell, t_cell;
	assign s_cell = {sy_q, sx_q};
	assign t_cell = {ty_q, tx_q};

	// heap children of u
	logic [HW:0] c2, c2p1, n_ext;
	assign c2    = {u_q, 1'b0};
	assign c2p1  = c2 + (HW+1)'(1);
	assign n_ext = {1'b0, n_q};

	// sift-down choice among sinking item, left and right child
	logic sel_l, sel_r;
	always_comb begin
		logic ge_l, ge_r, cur_ge_r;
		ge_l     = fsink_q >= fl_q;
		ge_r     = fsink_q >= f_rd;
		cur_ge_r = (ge_l ? fl_q : fsink_q) >= f_rd;
		sel_l = 1'b0;
		sel_r = 1'b0;
		if (has_r_q) begin
			if (mode_q) begin
				sel_r = cur_ge_r;
				sel_l = ge_l && !cur_ge_r;
			end else begin
				sel_l = ge_l;
				sel_r = ge_r && !ge_l;
			end
		end else begin
			sel_l = ge_l;
		end
	end

	// neighbor of the expanded cell
	logic [XW-1:0] px, nx, adx;
	logic [YW-1:0] py, ny, ady;
	logic          nb_diag, nb_ok;
	logic [AW-1:0] nb_cell;
	assign px = pc_q[XW-1:0];
	assign py = pc_q[AW-1:XW];
	always_comb begin
		nx = (dxi_q == 2'd0) ? px - XW'(1) : ((dxi_q == 2'd2) ? px + XW'(1) : px);
		ny = (dyi_q == 2'd0) ? py - YW'(1) : ((dyi_q == 2'd2) ? py + YW'(1) : py);
		nb_diag = (dxi_q != 2'd1) && (dyi_q != 2'd1);
		nb_ok = !(ortho_q && nb_diag)
			&& !(dxi_q == 2'd0 && px == '0)
			&& !(dxi_q == 2'd2 && px == XW'(GRID_W - 1))
			&& !(dyi_q == 2'd0 && py == '0)
			&& !(dyi_q == 2'd2 && py == YW'(GRID_H - 1));
		nb_cell = {ny, nx};
	end
	assign adx = (nc_q[XW-1:0] > tx_q) ? nc_q[XW-1:0] - tx_q : tx_q - nc_q[XW-1:0];
	assign ady = (nc_q[AW-1:XW] > ty_q) ? nc_q[AW-1:XW] - ty_q : ty_q - nc_q[AW-1:XW];

	logic su_swap;
	assign su_swap = (fnew_q < f_rd) || (allow_eq_q && fnew_q == f_rd);

	// RAM port steering
	always_comb begin
		walk_we = 1'b0; walk_wa = wcell_q; walk_wd = blk_q; walk_ra = nb_cell;
		mark_we = 1'b0; mark_wa = nc_q; mark_wd = MARK_OPEN; mark_ra = nb_cell;
		g_we = 1'b0; g_wa = nc_q; g_wd = gnew_q; g_ra = nb_cell;
		f_we = 1'b0; f_wa = nc_q; f_wd = fnew_q; f_ra = heap_rd;
		par_we = 1'b0; par_wa = nc_q; par_wd = pc_q; par_ra = pc_q;
		pos_we = 1'b0; pos_wa = nc_q; pos_wd = m_q; pos_ra = nb_cell;
		heap_we = 1'b0; heap_wa = m_q; heap_wd = nc_q; heap_ra = HW'(1);
		path_we = 1'b0; path_wa = PW'(len_q); path_wd = pc_q; path_ra = PW'(idx_q);
		case (state_q)
			S_INIT: begin
				walk_we = 1'b1; walk_wa = clr_q; walk_wd = 1'b0;
			end
			S_WR: walk_we = wr_ok_q;
			S_TGT: walk_ra = t_cell;
			S_CLR: begin
				mark_we = 1'b1; mark_wa = clr_q; mark_wd = MARK_NONE;
			end
			S_SEED: begin
				g_we = 1'b1; g_wa = s_cell; g_wd = '0;
				f_we = 1'b1; f_wa = s_cell; f_wd = '0;
				heap_we = 1'b1; heap_wa = HW'(1); heap_wd = s_cell;
			end
			S_POP1: begin
				heap_ra = n_q;
				mark_we = 1'b1; mark_wa = heap_rd; mark_wd = MARK_CLOSED;
			end
			S_POP2: begin
				heap_we = 1'b1; heap_wa = HW'(1); heap_wd = heap_rd;
				pos_we = 1'b1; pos_wa = heap_rd; pos_wd = HW'(1);
				f_ra = heap_rd;
				g_ra = pc_q;
			end
			S_SD0: heap_ra = HW'(c2);
			S_SD1: heap_ra = HW'(c2p1);
			S_SD3: begin
				heap_we = sel_l || sel_r; heap_wa = u_q; heap_wd = sel_l ? cl_q : cr_q;
				pos_we = sel_l || sel_r; pos_wa = sel_l ? cl_q : cr_q; pos_wd = u_q;
			end
			S_SD4: begin
				heap_we = 1'b1; heap_wa = v_q; heap_wd = sink_q;
				pos_we = 1'b1; pos_wa = sink_q; pos_wd = v_q;
			end
			S_NB3: begin
				g_we = 1'b1;
				f_we = 1'b1;
				par_we = 1'b1;
				if (!open_q) begin
					heap_we = 1'b1; heap_wa = n_q + HW'(1);
					pos_we = 1'b1; pos_wd = n_q + HW'(1);
					mark_we = 1'b1;
				end
			end
			S_SU0: heap_ra = m_q >> 1;
			S_SU2: begin
				heap_we = su_swap; heap_wd = cv_q;
				pos_we = su_swap; pos_wa = cv_q;
			end
			S_SU3: begin
				heap_we = 1'b1; heap_wa = m_q >> 1;
				pos_we = 1'b1; pos_wd = m_q >> 1;
			end
			S_PT0: begin
				path_we = 1'b1;
				path_wd = (pc_q == s_cell || len_q == LW'(CELLS - 1)) ? s_cell : pc_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			clr_q        <= '0;
			stored_len_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAPD - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						res_status_q <= STAT_DONE;
						res_x_q <= '0;
						res_y_q <= '0;
						state_q <= S_FIN;
						case (in_action)
							ACT_WRITE: state_q <= S_WR;
							ACT_SEARCH: begin
								if (32'(in_sx) >= GRID_W || 32'(in_sy) >= GRID_H
									|| 32'(in_tx) >= GRID_W || 32'(in_ty) >= GRID_H
									|| (in_sx == in_tx && in_sy == in_ty)) begin
									res_status_q <= STAT_NOPATH;
									stored_len_q <= '0;
								end else begin
									state_q <= S_TGT;
								end
							end
							ACT_READ: begin
								if (32'(in_idx) < CELLS && 32'(in_idx) < 32'(stored_len_q)) begin
									state_q <= S_RD0;
								end else begin
									res_status_q <= STAT_RANGE;
								end
							end
							default: ;
						endcase
					end
				end
				S_WR: state_q <= S_FIN;
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					res_x_q <= 5'(path_rd[XW-1:0]);
					res_y_q <= 5'(path_rd[AW-1:XW]);
					state_q <= S_FIN;
				end
				S_TGT: state_q <= S_TCHK;
				S_TCHK: begin
					clr_q <= '0;
					if (walk_rd) begin
						res_status_q <= STAT_NOPATH;
						stored_len_q <= '0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAPD - 1)) state_q <= S_SEED;
				end
				S_SEED: begin
					n_q <= HW'(1);
					tgt_open_q <= 1'b0;
					state_q <= S_POP0;
				end
				S_POP0: begin
					if (n_q == '0) begin
						res_status_q <= STAT_NOPATH;
						stored_len_q <= '0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_POP1;
					end
				end
				S_POP1: begin
					pc_q <= heap_rd;
					n_q <= n_q - HW'(1);
					state_q <= S_POP2;
				end
				S_POP2: begin
					sink_q <= heap_rd;
					state_q <= S_POP3;
				end
				S_POP3: begin
					g_pc_q <= g_rd;
					fsink_q <= f_rd;
					u_q <= HW'(1);
					state_q <= S_SD0;
				end
				S_SD0: begin
					has_r_q <= c2p1 <= n_ext;
					dxi_q <= '0;
					dyi_q <= '0;
					state_q <= (c2 > n_ext) ? S_NB0 : S_SD1;
				end
				S_SD1: begin
					cl_q <= heap_rd;
					state_q <= S_SD2;
				end
				S_SD2: begin
					cr_q <= heap_rd;
					fl_q <= f_rd;
					state_q <= S_SD3;
				end
				S_SD3: begin
					dxi_q <= '0;
					dyi_q <= '0;
					v_q <= sel_l ? HW'(c2) : HW'(c2p1);
					state_q <= (sel_l || sel_r) ? S_SD4 : S_NB0;
				end
				S_SD4: begin
					u_q <= v_q;
					state_q <= S_SD0;
				end
				S_NB0: begin
					nc_q <= nb_cell;
					diag_q <= nb_diag;
					state_q <= nb_ok ? S_NB1 : S_NEXT;
				end
				S_NB1: begin
					gnew_q <= g_pc_q + (diag_q ? GW'(COST_DIAG) : GW'(COST_STRAIGHT));
					hsum_q <= FW'(adx) + FW'(ady);
					open_q <= mark_rd == MARK_OPEN;
					gold_q <= g_rd;
					kpos_q <= pos_rd;
					state_q <= (mark_rd == MARK_CLOSED || walk_rd) ? S_NEXT : S_NB2;
				end
				S_NB2: begin
					fnew_q <= FW'(gnew_q) + (hsum_q << 3) + (hsum_q << 1);
					state_q <= (open_q && !(gnew_q < gold_q)) ? S_NEXT : S_NB3;
				end
				S_NB3: begin
					if (!open_q) begin
						m_q <= n_q + HW'(1);
						n_q <= n_q + HW'(1);
						allow_eq_q <= 1'b1;
						if (nc_q == t_cell) tgt_open_q <= 1'b1;
					end else begin
						m_q <= kpos_q;
						allow_eq_q <= 1'b0;
					end
					state_q <= S_SU0;
				end
				S_SU0: state_q <= (m_q == HW'(1)) ? S_NEXT : S_SU1;
				S_SU1: begin
					cv_q <= heap_rd;
					state_q <= S_SU2;
				end
				S_SU2: state_q <= su_swap ? S_SU3 : S_NEXT;
				S_SU3: begin
					m_q <= m_q >> 1;
					state_q <= S_SU0;
				end
				S_NEXT: begin
					if (dxi_q == 2'd2 && dyi_q == 2'd2) begin
						len_q <= '0;
						pc_q <= t_cell;
						state_q <= tgt_open_q ? S_PT0 : S_POP0;
					end else begin
						// skip the center cell
						if (dxi_q == 2'd2) begin
							dxi_q <= '0;
							dyi_q <= dyi_q + 2'd1;
						end else if (dyi_q == 2'd1 && dxi_q == 2'd0) begin
							dxi_q <= 2'd2;
						end else begin
							dxi_q <= dxi_q + 2'd1;
						end
						state_q <= S_NB0;
					end
				end
				S_PT0: begin
					len_q <= len_q + LW'(1);
					if (pc_q == s_cell || len_q == LW'(CELLS - 1)) begin
						stored_len_q <= len_q + LW'(1);
						res_status_q <= STAT_FOUND;
						state_q <= S_FIN;
					end else begin
						state_q <= S_PT1;
					end
				end
				S_PT1: begin
					pc_q <= par_rd;
					state_q <= S_PT0;
				end
				S_FIN: begin
					if (!m_valid_q || m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// word capture and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			sx_q    <= XW'(in_sx);
			sy_q    <= YW'(in_sy);
			tx_q    <= XW'(in_tx);
			ty_q    <= YW'(in_ty);
			ortho_q <= in_ortho;
			mode_q  <= in_mode;
			idx_q   <= in_idx;
			blk_q   <= in_blk;
			wcell_q <= {YW'(in_cy), XW'(in_cx)};
			wr_ok_q <= 32'(in_cx) < GRID_W && 32'(in_cy) < GRID_H;
		end
		if (state_q == S_FIN && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {3'b000, res_y_q, res_x_q, 11'(stored_len_q)};
			m_user_q <= res_status_q;
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	gap_ram #(.WIDTH(1), .DEPTH(MAPD)) u_walk (
		.clk(clk), .we(walk_we), .waddr(walk_wa), .wdata(walk_wd), .raddr(walk_ra),
		.rdata(walk_rd)
	);
	gap_ram #(.WIDTH(2), .DEPTH(MAPD)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd), .raddr(mark_ra),
		.rdata(mark_rd)
	);
	gap_ram #(.WIDTH(GW), .DEPTH(MAPD)) u_gcost (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
	);
	gap_ram #(.WIDTH(FW), .DEPTH(MAPD)) u_fcost (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
	);
	gap_ram #(.WIDTH(AW), .DEPTH(MAPD)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra),
		.rdata(par_rd)
	);
	gap_ram #(.WIDTH(HW), .DEPTH(MAPD)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra),
		.rdata(pos_rd)
	);
	gap_ram #(.WIDTH(AW), .DEPTH(HD)) u_heap (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd), .raddr(heap_ra),
		.rdata(heap_rd)
	);
	gap_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_path (
		.clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd), .raddr(path_ra),
		.rdata(path_rd)
	);

endmodule

// ===== design/gap_checker.sv =====
// Port-level checker for the path search core, bound to the top level.
`include "assert_macros.svh"

module gap_checker
	import gap_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]             m_axis_tuser
);

	`GAP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
	`GAP_ASSERT_NEXT(a_one_word, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while one is in work")
	`GAP_ASSERT_IMPLY(a_no_coords, clk, arst_n, m_axis_tvalid && m_axis_tuser != STAT_DONE, m_axis_tdata[20:11] == 10'd0, "path cell given outside a read")
	`GAP_ASSERT_IMPLY(a_nopath_len, clk, arst_n, m_axis_tvalid && m_axis_tuser == STAT_NOPATH, m_axis_tdata[10:0] == 11'd0, "length kept after a failed search")

endmodule

bind grid_astar_path_search_core gap_checker u_gap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== verif/tb_grid_astar_path_search_core.sv =====
// Self-checking testbench for the A* grid path search core: directed table, then random traffic.
module tb_grid_astar_path_search_core;
	import gap_pkg::*;

	localparam int GW = 32;
	localparam int GH = 32;
	localparam int NCELL = GW * GH;

	typedef struct {
		logic [1:0] act;
		logic [4:0] cx, cy;
		logic       cb;
		logic [4:0] sx, sy, tx, ty;
		logic       dof, tie;
		logic [9:0] pidx;
	} cmd_word_t;

	typedef struct {
		logic [1:0]  st;
		logic [10:0] len;
		logic [4:0]  x, y;
	} path_result_t;

	typedef struct {
		cmd_word_t    w;
		bit           typed;
		path_result_t r;
	} table_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [1:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;

	grid_astar_path_search_core #(.GRID_W(GW), .GRID_H(GH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// predictor state
	bit          walk_blk [NCELL];
	logic [1:0]  mark [NCELL];
	int unsigned g_of [NCELL];
	int unsigned parent_of [NCELL];
	int unsigned hslot [NCELL+2];
	int unsigned hcell [NCELL+2];
	int unsigned hf [NCELL+2];
	int unsigned route [NCELL];
	int unsigned route_len;

	path_result_t pending_results[$];
	int           fail_count;
	int           send_idle_pct;
	int           recv_idle_pct;
	bit           hold_req;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int unsigned adiff(int unsigned a, int unsigned b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic int unsigned f_at(int unsigned s);
		return hf[hslot[s]];
	endfunction

	function automatic void swap_slot(int unsigned a, int unsigned b);
		int unsigned t;
		t = hslot[a];
		hslot[a] = hslot[b];
		hslot[b] = t;
	endfunction

	function automatic void heap_down(int unsigned n, bit tie);
		int unsigned u, v;
		v = 1;
		forever begin
			u = v;
			if (2*u + 1 <= n) begin
				if (tie) begin
					if (f_at(u) >= f_at(2*u)) v = 2*u;
					if (f_at(v) >= f_at(2*u+1)) v = 2*u + 1;
				end else begin
					if (f_at(v) >= f_at(2*u+1)) v = 2*u + 1;
					if (f_at(u) >= f_at(2*u)) v = 2*u;
				end
			end else if (2*u <= n) begin
				if (f_at(u) >= f_at(2*u)) v = 2*u;
			end
			if (u == v) break;
			swap_slot(u, v);
		end
	endfunction

	function automatic void heap_up(int unsigned m, bit allow_eq);
		int unsigned c, p;
		while (m != 1) begin
			c = f_at(m);
			p = f_at(m/2);
			if (c < p || (allow_eq && c == p)) begin
				swap_slot(m, m/2);
				m = m / 2;
			end else begin
				break;
			end
		end
	endfunction

	function automatic bit astar_search(int unsigned sx, int unsigned sy, int unsigned tx,
			int unsigned ty, bit ortho, bit tie);
		int unsigned n, next_id, scell, tcell, pc, px, py, nc, g, h, m, k, c, len;
		int nx, ny;
		bit diag;
		next_id = 0;
		if (sx == tx && sy == ty) return 1'b0;
		tcell = ty * GW + tx;
		scell = sy * GW + sx;
		if (walk_blk[tcell]) return 1'b0;
		foreach (mark[i]) mark[i] = MARK_NONE;
		g_of[scell] = 0;
		n = 1;
		hslot[1] = 0;
		hcell[0] = scell;
		hf[0] = 0;
		forever begin
			if (n == 0) return 1'b0;
			pc = hcell[hslot[1]];
			px = pc % GW;
			py = pc / GW;
			mark[pc] = MARK_CLOSED;
			n--;
			hslot[1] = hslot[n+1];
			heap_down(n, tie);
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					diag = (dx != 0 && dy != 0);
					nx = int'(px) + dx;
					ny = int'(py) + dy;
					if (ortho && diag) continue;
					if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
					nc = ny * GW + nx;
					if (mark[nc] == MARK_CLOSED) continue;
					if (walk_blk[nc]) continue;
					g = g_of[pc] + (diag ? COST_DIAG : COST_STRAIGHT);
					h = 10 * (adiff(nx, tx) + adiff(ny, ty));
					if (mark[nc] != MARK_OPEN) begin
						if (next_id < NCELL) next_id++;
						m = n + 1;
						hslot[m] = next_id;
						hcell[next_id] = nc;
						g_of[nc] = g;
						hf[next_id] = g + h;
						parent_of[nc] = pc;
						heap_up(m, 1'b1);
						n++;
						mark[nc] = MARK_OPEN;
					end else if (g < g_of[nc]) begin
						parent_of[nc] = pc;
						g_of[nc] = g;
						for (k = 1; k <= n; k++) begin
							if (hcell[hslot[k]] == nc) begin
								hf[hslot[k]] = g + h;
								heap_up(k, 1'b0);
								break;
							end
						end
					end
				end
			end
			if (mark[tcell] == MARK_OPEN) break;
		end
		c = tcell;
		len = 0;
		while (c != scell && len < NCELL - 1) begin
			route[len] = c;
			len++;
			c = parent_of[c] % NCELL;
		end
		route[len] = scell;
		len++;
		route_len = len;
		return 1'b1;
	endfunction

	function automatic path_result_t astar_predict(cmd_word_t w);
		path_result_t r;
		r = '{STAT_DONE, 11'd0, 5'd0, 5'd0};
		if (w.act == ACT_WRITE) begin
			walk_blk[w.cy * GW + w.cx] = w.cb;
		end else if (w.act == ACT_SEARCH) begin
			if (astar_search(w.sx, w.sy, w.tx, w.ty, w.dof, w.tie)) begin
				r.st = STAT_FOUND;
			end else begin
				r.st = STAT_NOPATH;
				route_len = 0;
			end
		end else if (w.act == ACT_READ) begin
			if (w.pidx < route_len) begin
				r.x = 5'(route[w.pidx] % GW);
				r.y = 5'(route[w.pidx] / GW);
			end else begin
				r.st = STAT_RANGE;
			end
		end
		r.len = 11'(route_len);
		return r;
	endfunction

	function automatic cmd_word_t w_write(int x, int y, bit b);
		cmd_word_t w;
		w = '{ACT_WRITE, 5'(x), 5'(y), b, 5'($urandom), 5'($urandom), 5'($urandom),
			5'($urandom), 1'($urandom), 1'($urandom), 10'($urandom)};
		return w;
	endfunction

	function automatic cmd_word_t w_search(int sx, int sy, int tx, int ty, bit dof, bit tie);
		cmd_word_t w;
		w = '{ACT_SEARCH, 5'($urandom), 5'($urandom), 1'($urandom), 5'(sx), 5'(sy), 5'(tx),
			5'(ty), dof, tie, 10'($urandom)};
		return w;
	endfunction

	function automatic cmd_word_t w_read(int idx, logic [1:0] act);
		cmd_word_t w;
		w = '{act, 5'($urandom), 5'($urandom), 1'($urandom), 5'($urandom), 5'($urandom),
			5'($urandom), 5'($urandom), 1'($urandom), 1'($urandom), 10'(idx)};
		return w;
	endfunction

	// offer one word, hold it until accepted, then queue its expected result
	task automatic send_word(cmd_word_t w, bit typed, path_result_t typed_r);
		path_result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.act;
		s_axis_tdata  <= {5'd0, w.pidx, w.tie, w.dof, w.ty, w.tx, w.sy, w.sx, w.cb, w.cy, w.cx};
		do @(posedge clk); while (!s_axis_tready);
		r = astar_predict(w);
		pending_results.push_back(typed ? typed_r : r);
		@(negedge clk);
	endtask

	task automatic run_random(int count);
		int n, k, reads;
		n = 0;
		while (n < count) begin
			k = $urandom_range(99);
			if (k < 30) begin
				send_word(w_write($urandom_range(GW-1), $urandom_range(GH-1),
					$urandom_range(99) < 30), 1'b0, '{default:0});
				n++;
			end else if (k < 85) begin
				send_word(w_search($urandom_range(GW-1), $urandom_range(GH-1),
					$urandom_range(GW-1), $urandom_range(GH-1), 1'($urandom),
					1'($urandom)), 1'b0, '{default:0});
				reads = $urandom_range(1, 4);
				n += 1 + reads;
				repeat (reads)
					send_word(w_read($urandom_range(route_len + 1), ACT_READ), 1'b0,
						'{default:0});
			end else if (k < 95) begin
				send_word(w_read($urandom_range(1023), ACT_READ), 1'b0, '{default:0});
				n++;
			end else begin
				send_word(w_read($urandom_range(1023), 2'd3), 1'b0, '{default:0});
				n++;
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off when requested
	always @(negedge clk) begin
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			for (int i = 0; i < 300; i++) @(negedge clk);
			hold_req = 1'b0;
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		path_result_t exp_r, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[10:0], m_axis_tdata[15:11], m_axis_tdata[20:16]};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word status=%0d len=%0d x=%0d y=%0d", $time,
					got.st, got.len, got.x, got.y);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.st !== exp_r.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
					fail_count++;
				end
				if (got.len !== exp_r.len) begin
					$display("%0t: path_length expected %0d actual %0d", $time, exp_r.len,
						got.len);
					fail_count++;
				end
				if (got.x !== exp_r.x) begin
					$display("%0t: step_x expected %0d actual %0d", $time, exp_r.x, got.x);
					fail_count++;
				end
				if (got.y !== exp_r.y) begin
					$display("%0t: step_y expected %0d actual %0d", $time, exp_r.y, got.y);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1_500_000_000;
		$display("tb_grid_astar_path_search_core failed");
		$finish;
	end

	initial begin
		table_row_t rows[$];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_WRITE;
		m_axis_tready = 1'b0;
		hold_req      = 1'b0;
		fail_count    = 0;
		send_idle_pct = 25;
		recv_idle_pct = 84;
		foreach (walk_blk[i]) walk_blk[i] = 1'b0;
		route_len = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		rows.push_back('{w_read(0, ACT_READ), 1'b1, '{STAT_RANGE, 11'd0, 5'd0, 5'd0}});
		rows.push_back('{w_read(1023, ACT_READ), 1'b1, '{STAT_RANGE, 11'd0, 5'd0, 5'd0}});
		rows.push_back('{w_read(1023, 2'd3), 1'b1, '{STAT_DONE, 11'd0, 5'd0, 5'd0}});
		rows.push_back('{w_write(31, 31, 1), 1'b1, '{STAT_DONE, 11'd0, 5'd0, 5'd0}});
		// blocked target
		rows.push_back('{w_search(0, 0, 31, 31, 0, 1), 1'b1,
			'{STAT_NOPATH, 11'd0, 5'd0, 5'd0}});
		rows.push_back('{w_write(31, 31, 0), 1'b1, '{STAT_DONE, 11'd0, 5'd0, 5'd0}});
		// start equal to target
		rows.push_back('{w_search(5, 5, 5, 5, 0, 0), 1'b1, '{STAT_NOPATH, 11'd0, 5'd0, 5'd0}});
		rows.push_back('{w_search(0, 0, 31, 31, 0, 1), 1'b0, '{default:0}});
		rows.push_back('{w_read(0, ACT_READ), 1'b0, '{default:0}});
		rows.push_back('{w_read(31, ACT_READ), 1'b0, '{default:0}});
		rows.push_back('{w_read(1023, ACT_READ), 1'b0, '{default:0}});
		rows.push_back('{w_search(31, 0, 0, 31, 1, 0), 1'b0, '{default:0}});
		rows.push_back('{w_read(5, ACT_READ), 1'b0, '{default:0}});
		// blocked start still expands
		rows.push_back('{w_write(3, 3, 1), 1'b0, '{default:0}});
		rows.push_back('{w_search(3, 3, 10, 3, 0, 1), 1'b0, '{default:0}});
		rows.push_back('{w_read(1, ACT_READ), 1'b0, '{default:0}});
		// wall the start corner in so the open list runs dry
		rows.push_back('{w_write(1, 0, 1), 1'b0, '{default:0}});
		rows.push_back('{w_write(0, 1, 1), 1'b0, '{default:0}});
		rows.push_back('{w_write(1, 1, 1), 1'b0, '{default:0}});
		rows.push_back('{w_search(0, 0, 20, 20, 0, 0), 1'b0, '{default:0}});
		rows.push_back('{w_search(0, 0, 20, 20, 1, 1), 1'b0, '{default:0}});
		rows.push_back('{w_read(0, ACT_READ), 1'b0, '{default:0}});
		foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);

		run_random(24);
		send_idle_pct = 84;
		recv_idle_pct = 25;
		run_random(24);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (10) send_word(w_write($urandom_range(GW-1), $urandom_range(GH-1), 0), 1'b0,
			'{default:0});
		run_random(20);
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("tb_grid_astar_path_search_core passed");
		else
			$display("tb_grid_astar_path_search_core failed");
		$finish;
	end

endmodule
